// ----- rtl/ecpr_pkg.sv -----
// Shared constants, types and helpers of the enhanced clock page replacer.
package ecpr_pkg;

	localparam int NUM_FRAMES = 16;
	localparam int NUM_PAGES  = 256;
	localparam int PAGE_SHIFT = 4;
	localparam int COORD_W    = 8;
	localparam int FRAME_W    = $clog2(NUM_FRAMES);
	localparam int PAGE_W     = $clog2(NUM_PAGES);
	localparam int CNT_W      = 32;

	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	// One page table entry.
	typedef struct packed {
		logic   valid;
		frame_t frame;
	} slot_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic accept;
		logic hit_done;
		logic sweep;
		logic evict;
		logic install;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic hit;
		logic stop;
		logic out_busy;
	} sts_t;

	// Page table contents after reset: page i sits in frame i for the first frames.
	function automatic slot_t reset_slot(page_t p);
		slot_t s;
		s.valid = (int'(p) < NUM_FRAMES);
		s.frame = frame_t'(p);
		return s;
	endfunction

	function automatic frame_t next_frame(frame_t f);
		return (int'(f) == NUM_FRAMES - 1) ? '0 : frame_t'(f + 1'b1);
	endfunction

	function automatic cnt_t sat_inc(cnt_t c);
		return (c == '1) ? c : cnt_t'(c + 1'b1);
	endfunction

endpackage

// ----- rtl/ecpr_ctrl.sv -----
// Controller state machine: lookup, clock sweep, eviction and install sequencing.
module ecpr_ctrl import ecpr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_LOOK    = 3'd1;
	localparam logic [2:0] ST_SWEEP   = 3'd2;
	localparam logic [2:0] ST_EVICT   = 3'd3;
	localparam logic [2:0] ST_INSTALL = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (!sts.hit) begin
					state_d = ST_SWEEP;
				end else if (!sts.out_busy) begin
					cmd.hit_done = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.stop) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				state_d   = ST_INSTALL;
			end
			ST_INSTALL: begin
				if (!sts.out_busy) begin
					cmd.install = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/ecpr_dp.sv -----
// Datapath: page table memory, frame bits, clock hand, counters and result register.
module ecpr_dp import ecpr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic                req_type,
	input  logic [COORD_W-1:0]  x_coord,
	input  logic [COORD_W-1:0]  y_coord,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                was_hit,
	output logic [FRAME_W-1:0]  frame_index,
	output logic [PAGE_W-1:0]   evicted_page,
	output logic [CNT_W-1:0]    hit_total,
	output logic [CNT_W-1:0]    miss_total
);

	slot_t                slot_mem [NUM_PAGES];
	logic [NUM_PAGES-1:0] written_q;
	slot_t                rdata_q;

	page_t                frame_page_q [NUM_FRAMES];
	logic [NUM_FRAMES-1:0] ref_q;
	logic [NUM_FRAMES-1:0] mod_q;
	frame_t               hand_q;
	cnt_t                 hit_cnt_q;
	cnt_t                 miss_cnt_q;

	page_t                page_q;
	logic                 wr_q;
	page_t                old_q;

	page_t                in_page;
	page_t                rd_addr;
	logic                 rd_en;
	slot_t                look_slot;
	slot_t                old_slot;
	logic                 mem_we;
	page_t                mem_waddr;
	slot_t                mem_wdata;
	logic                 hand_r;
	logic                 hand_m;
	cnt_t                 hit_cnt_inc;
	cnt_t                 miss_cnt_inc;

	assign in_page = page_t'({y_coord[COORD_W-1:PAGE_SHIFT], x_coord[COORD_W-1:PAGE_SHIFT]});

	// Entries never written since reset read as their reset mapping.
	assign look_slot = written_q[page_q] ? rdata_q : reset_slot(page_q);
	assign old_slot  = written_q[old_q]  ? rdata_q : reset_slot(old_q);

	assign hand_r = ref_q[hand_q];
	assign hand_m = mod_q[hand_q];

	assign sts.hit      = look_slot.valid;
	assign sts.stop     = !hand_r && !hand_m;
	assign sts.out_busy = out_valid && !out_ready;

	assign hit_cnt_inc  = sat_inc(hit_cnt_q);
	assign miss_cnt_inc = sat_inc(miss_cnt_q);

	// Single read port: lookup on accept, victim's old page when the sweep stops.
	assign rd_en   = cmd.accept || (cmd.sweep && sts.stop);
	assign rd_addr = cmd.accept ? in_page : frame_page_q[hand_q];

	always_comb begin
		mem_we          = 1'b0;
		mem_waddr       = page_q;
		mem_wdata.valid = 1'b1;
		mem_wdata.frame = hand_q;
		if (cmd.evict) begin
			// drop the old mapping only if it still points at this frame
			mem_we          = old_slot.valid && (old_slot.frame == hand_q);
			mem_waddr       = old_q;
			mem_wdata.valid = 1'b0;
		end else if (cmd.install) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= slot_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (mem_we) begin
			written_q[mem_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			page_q <= in_page;
			wr_q   <= req_type;
		end
		if (cmd.sweep && sts.stop) begin
			old_q <= frame_page_q[hand_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FRAMES; i++) begin
				frame_page_q[i] <= page_t'(i);
			end
			ref_q        <= '0;
			mod_q        <= '0;
			hand_q       <= '0;
			hit_cnt_q    <= '0;
			miss_cnt_q   <= '0;
			out_valid    <= 1'b0;
			was_hit      <= 1'b0;
			frame_index  <= '0;
			evicted_page <= '0;
			hit_total    <= '0;
			miss_total   <= '0;
		end else begin
			if (cmd.hit_done || cmd.install) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmd.hit_done) begin
				ref_q[look_slot.frame] <= 1'b1;
				if (wr_q) begin
					mod_q[look_slot.frame] <= 1'b1;
				end
				hit_cnt_q    <= hit_cnt_inc;
				was_hit      <= 1'b1;
				frame_index  <= look_slot.frame;
				evicted_page <= '0;
				hit_total    <= hit_cnt_inc;
				miss_total   <= miss_cnt_q;
			end
			if (cmd.sweep && !sts.stop) begin
				// 11 -> 01, 10 or 01 -> 00
				ref_q[hand_q] <= 1'b0;
				mod_q[hand_q] <= hand_r && hand_m;
				hand_q        <= next_frame(hand_q);
			end
			if (cmd.install) begin
				frame_page_q[hand_q] <= page_q;
				ref_q[hand_q]        <= 1'b1;
				mod_q[hand_q]        <= wr_q;
				hand_q               <= next_frame(hand_q);
				miss_cnt_q           <= miss_cnt_inc;
				was_hit              <= 1'b0;
				frame_index          <= hand_q;
				evicted_page         <= old_q;
				hit_total            <= hit_cnt_q;
				miss_total           <= miss_cnt_inc;
			end
		end
	end

endmodule

// ----- rtl/enhanced_clock_page_replacer_core.sv -----
// Hit: accept, then page table lookup. Miss: accept, lookup, a sweep passing over k = 0..32
// frames as the clock hand examines one frame per cycle, then evict and install.
// Results sit in an output register; a new word is taken while a result waits.
// Reset (arst_n, asynchronous, active low) restores the frame table, clears all
// bits, hand and counters at once; per-page written flags make the page table read
// as its reset mapping, so there is no clearing pass.
module enhanced_clock_page_replacer_core import ecpr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [COORD_W-1:0] x_coord,
	input  logic [COORD_W-1:0] y_coord,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               was_hit,
	output logic [FRAME_W-1:0] frame_index,
	output logic [PAGE_W-1:0]  evicted_page,
	output logic [CNT_W-1:0]   hit_total,
	output logic [CNT_W-1:0]   miss_total
);

	cmd_t cmd;
	sts_t sts;

	ecpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ecpr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.was_hit      (was_hit),
		.frame_index  (frame_index),
		.evicted_page (evicted_page),
		.hit_total    (hit_total),
		.miss_total   (miss_total)
	);

endmodule

// ----- rtl/ecpr_checker.sv -----
// Port-level checker for the page replacer, bound to the top level.
module ecpr_checker import ecpr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               was_hit,
	input logic [FRAME_W-1:0] frame_index,
	input logic [PAGE_W-1:0]  evicted_page,
	input logic [CNT_W-1:0]   hit_total,
	input logic [CNT_W-1:0]   miss_total
);

	// a waiting result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(was_hit) && $stable(frame_index)
			&& $stable(evicted_page) && $stable(hit_total) && $stable(miss_total))
		else $error("result word changed while stalled");

	// inputs are never accepted back to back
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in back-to-back cycles");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_hit |-> evicted_page == '0)
		else $error("hit reports an evicted page");

	// the counter matching the result kind already includes this access
	a_count_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (was_hit && hit_total != '0) || (!was_hit && miss_total != '0))
		else $error("counter does not include this access");

endmodule

bind enhanced_clock_page_replacer_core ecpr_checker u_ecpr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.was_hit      (was_hit),
	.frame_index  (frame_index),
	.evicted_page (evicted_page),
	.hit_total    (hit_total),
	.miss_total   (miss_total)
);
